### rtl/asx_pkg.sv
// shared constants, codes and types of the entry store with extreme search and sort
`default_nettype none

package asx_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_EMIT      = 16;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = 4;
   localparam int CNT_W         = 5;
   localparam int CMD_W         = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 40;

   localparam logic [CNT_W-1:0] USED_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXTREME = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SORT    = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic                     descending;
      logic                     bad_index;
   } job_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [IDX_W-1:0]         position;
      logic                     last;
      logic                     bad_index;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN_START,
      ST_SCAN_HEAD,
      ST_SCAN,
      ST_SCAN_DONE,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_EMIT_START,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

### rtl/asx_front.sv
// request front end: unpacks request words, checks write indexes, drops unused commands
`default_nettype none

module asx_front (
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // index[3:0], value[35:4], descending[36], zero fill
   input  wire logic [asx_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command[1:0]
   input  wire logic [asx_pkg::CMD_W-1:0]         req_tuser,
   input  wire logic [asx_pkg::CNT_W-1:0]         used_count,
   input  wire asx_pkg::queue_status_type         queue_status,
   output      logic                              push,
   output      asx_pkg::job_type                  push_job
);

   logic [asx_pkg::IDX_W-1:0] index;
   logic                      is_write;

   assign index      = req_tdata[asx_pkg::IDX_W-1:0];
   assign req_tready = !queue_status.full;
   assign is_write   = (req_tuser == asx_pkg::CMD_WRITE);

   always_comb begin
      push_job.command    = req_tuser;
      push_job.index      = index;
      push_job.value      = req_tdata[asx_pkg::IDX_W +: asx_pkg::DATA_W];
      push_job.descending = req_tdata[asx_pkg::IDX_W + asx_pkg::DATA_W];
      push_job.bad_index  = is_write &&
                            ({1'b0, index} >= used_count);
   end

   always_comb begin
      case (req_tuser)
         asx_pkg::CMD_WRITE, asx_pkg::CMD_EXTREME, asx_pkg::CMD_SORT: begin
            push = req_tvalid && req_tready;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/asx_fifo.sv
// short command queue between the front end and the sequencer
`default_nettype none

module asx_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire asx_pkg::job_type          push_job,
   input  wire logic                      pop,
   output      asx_pkg::job_type          pop_job,
   output      asx_pkg::queue_status_type status
);

   localparam int PW = (asx_pkg::QUEUE_DEPTH > 1) ? $clog2(asx_pkg::QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(asx_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(asx_pkg::QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(asx_pkg::QUEUE_DEPTH);

   asx_pkg::job_type slot_ff [asx_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FILL_MAX);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/asx_engine.sv
// sequencer with the entry memory, one shared comparator and the response register
`default_nettype none

module asx_engine #(
   parameter int DEPTH = asx_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [asx_pkg::CNT_W-1:0]         used_count,
   input  wire asx_pkg::queue_status_type         queue_status,
   input  wire asx_pkg::job_type                  head_job,
   output      logic                              pop,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // result_value[31:0], position[35:32], zero fill
   output      logic [asx_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // bad_index
   output      logic                              rsp_tuser,
   output      logic                              rsp_tlast
);

   localparam int LIM = (DEPTH < asx_pkg::MAX_EMIT) ? DEPTH : asx_pkg::MAX_EMIT;
   localparam int AW  = $clog2(LIM);
   localparam int CW  = asx_pkg::CNT_W;
   localparam int DW  = asx_pkg::DATA_W;
   localparam int IW  = asx_pkg::IDX_W;

   logic [DW-1:0] mem [LIM];
   logic [LIM-1:0] valid_ff;
   logic [DW-1:0]  rd_data_ff;
   logic           rd_valid_ff;
   logic [AW-1:0]  rd_idx_ff;

   asx_pkg::state_type state_ff, state_in;
   asx_pkg::job_type   job_ff, job_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [AW-1:0]      sel_ff, sel_in;
   logic signed [DW-1:0] best_ff, best_in;
   logic signed [DW-1:0] head_ff, head_in;
   asx_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic                 we, re, load, out_free, take;
   logic [AW-1:0]        wa, ra;
   logic [DW-1:0]        wd;
   logic signed [DW-1:0] rd_value;

   assign rd_value = rd_valid_ff ? rd_data_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign take     = job_ff.descending ? (best_ff < rd_value) : (rd_value < best_ff);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      sel_in   = sel_ff;
      best_in  = best_ff;
      head_in  = head_ff;
      rsp_in   = rsp_ff;
      pop      = 1'b0;
      load     = 1'b0;
      we       = 1'b0;
      wa       = '0;
      wd       = '0;
      re       = 1'b0;
      ra       = '0;
      unique case (state_ff)
         asx_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               pop    = 1'b1;
               job_in = head_job;
               i_in   = '0;
               unique case (head_job.command)
                  asx_pkg::CMD_WRITE:   state_in = asx_pkg::ST_WRITE;
                  asx_pkg::CMD_EXTREME: state_in = asx_pkg::ST_SCAN_START;
                  asx_pkg::CMD_SORT: begin
                     state_in = (used_count > 5'd1) ? asx_pkg::ST_SCAN_START
                                                    : asx_pkg::ST_EMIT_START;
                  end
                  default: state_in = asx_pkg::ST_IDLE;
               endcase
            end
         end
         asx_pkg::ST_WRITE: begin
            if (out_free) begin
               we                  = !job_ff.bad_index;
               wa                  = job_ff.index[AW-1:0];
               wd                  = job_ff.value;
               load                = 1'b1;
               rsp_in.result_value = job_ff.value;
               rsp_in.position     = job_ff.index;
               rsp_in.last         = 1'b1;
               rsp_in.bad_index    = job_ff.bad_index;
               state_in            = asx_pkg::ST_IDLE;
            end
         end
         asx_pkg::ST_SCAN_START: begin
            re       = 1'b1;
            ra       = i_ff[AW-1:0];
            j_in     = i_ff + 1'b1;
            state_in = asx_pkg::ST_SCAN_HEAD;
         end
         asx_pkg::ST_SCAN_HEAD: begin
            best_in = rd_value;
            head_in = rd_value;
            sel_in  = rd_idx_ff;
            if (j_ff < used_count) begin
               re       = 1'b1;
               ra       = j_ff[AW-1:0];
               j_in     = j_ff + 1'b1;
               state_in = asx_pkg::ST_SCAN;
            end else begin
               state_in = asx_pkg::ST_SCAN_DONE;
            end
         end
         asx_pkg::ST_SCAN: begin
            if (take) begin
               best_in = rd_value;
               sel_in  = rd_idx_ff;
            end
            if (j_ff < used_count) begin
               re   = 1'b1;
               ra   = j_ff[AW-1:0];
               j_in = j_ff + 1'b1;
            end else begin
               state_in = asx_pkg::ST_SCAN_DONE;
            end
         end
         asx_pkg::ST_SCAN_DONE: begin
            if (job_ff.command == asx_pkg::CMD_SORT) begin
               state_in = asx_pkg::ST_SWAP_A;
            end else if (out_free) begin
               load                = 1'b1;
               rsp_in.result_value = best_ff;
               rsp_in.position     = '0;
               rsp_in.last         = 1'b1;
               rsp_in.bad_index    = 1'b0;
               state_in            = asx_pkg::ST_IDLE;
            end
         end
         asx_pkg::ST_SWAP_A: begin
            we       = 1'b1;
            wa       = i_ff[AW-1:0];
            wd       = best_ff;
            state_in = asx_pkg::ST_SWAP_B;
         end
         asx_pkg::ST_SWAP_B: begin
            we   = 1'b1;
            wa   = sel_ff;
            wd   = head_ff;
            i_in = i_ff + 1'b1;
            state_in = (CW'(i_ff + 5'd2) < used_count) ? asx_pkg::ST_SCAN_START
                                                        : asx_pkg::ST_EMIT_START;
         end
         asx_pkg::ST_EMIT_START: begin
            re       = 1'b1;
            ra       = '0;
            j_in     = 5'd1;
            state_in = asx_pkg::ST_EMIT;
         end
         asx_pkg::ST_EMIT: begin
            if (out_free) begin
               load                = 1'b1;
               rsp_in.result_value = rd_value;
               rsp_in.position     = IW'(rd_idx_ff);
               rsp_in.last         = (CW'(rd_idx_ff) + 5'd1 == used_count);
               rsp_in.bad_index    = 1'b0;
               if (CW'(rd_idx_ff) + 5'd1 == used_count) begin
                  state_in = asx_pkg::ST_IDLE;
               end else begin
                  re   = 1'b1;
                  ra   = j_ff[AW-1:0];
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = asx_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asx_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (we) begin
            valid_ff[wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      sel_ff  <= sel_in;
      best_ff <= best_in;
      head_ff <= head_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_data_ff  <= mem[ra];
         rd_valid_ff <= valid_ff[ra];
         rd_idx_ff   <= ra;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(asx_pkg::RSP_TDATA_W - DW - IW){1'b0}},
                        rsp_ff.position, rsp_ff.result_value};
   assign rsp_tuser  = rsp_ff.bad_index;
   assign rsp_tlast  = rsp_ff.last;

endmodule

`default_nettype wire

### rtl/array_store_extreme_and_sort_core.sv
// top level: used-count register, front end, command queue and sequencer
// write: response loaded in ST_WRITE; extreme: in ST_SCAN_DONE after a scan of the used entries
// sort: scans each with a swap, then an emit pass; one memory read per cycle during a scan
// commands run one at a time in the sequencer; two more words wait in the queue
// reset clears the per-entry valid bits directly, no clearing pass; used count resets to 16
`default_nettype none

module array_store_extreme_and_sort_core #(
   parameter int DEPTH = asx_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // index[3:0], value[35:4], descending[36], zero fill
   input  wire logic [asx_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command[1:0]
   input  wire logic [asx_pkg::CMD_W-1:0]         req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // result_value[31:0], position[35:32], zero fill
   output      logic [asx_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // bad_index
   output      logic                              rsp_tuser,
   output      logic                              rsp_tlast,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [asx_pkg::CNT_W-1:0]         csr_data
);

   localparam int LIM = (DEPTH < asx_pkg::MAX_EMIT) ? DEPTH : asx_pkg::MAX_EMIT;
   localparam logic [asx_pkg::CNT_W-1:0] LIM_CNT = asx_pkg::CNT_W'(LIM);

   logic [asx_pkg::CNT_W-1:0] used_ff, used_in;
   logic [asx_pkg::CNT_W-1:0] used_count;

   asx_pkg::queue_status_type queue_status;
   asx_pkg::job_type          push_job, head_job;
   logic                      push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      used_in = used_ff;
      if (csr_valid && csr_ready) begin
         used_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= asx_pkg::USED_RESET;
      end else begin
         used_ff <= used_in;
      end
   end

   always_comb begin
      if (used_ff == '0) begin
         used_count = 5'd1;
      end else if (used_ff > LIM_CNT) begin
         used_count = LIM_CNT;
      end else begin
         used_count = used_ff;
      end
   end

   asx_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .used_count   (used_count),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   asx_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (head_job),
      .status   (queue_status)
   );

   asx_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .used_count   (used_count),
      .queue_status (queue_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire
